// ===== sv/kbd_pkg.sv =====
// Shared constants and types for the keyboard scan decoder.
package kbd_pkg;

	localparam int BLINK_BITS = 5;
	localparam int TICKS_W    = 16;
	localparam int MAP_DEPTH  = 256;
	localparam int MAP_AW     = $clog2(MAP_DEPTH);

	localparam logic [7:0] REPEAT_DELAY_RESET = 8'd10;
	localparam logic [7:0] MOUSE_MASK   = 8'hFC;
	localparam logic [7:0] MOUSE_HEADER = 8'hF8;
	localparam logic [7:0] LSHIFT_MAKE  = 8'h2A;
	localparam logic [7:0] RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] LSHIFT_BREAK = 8'hAA;
	localparam logic [7:0] RSHIFT_BREAK = 8'hB6;

	localparam logic [TICKS_W-1:0] TICKS_MAX = {TICKS_W{1'b1}};

	// input item kinds
	localparam logic [1:0] MODE_BYTE = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_LOAD = 2'd2;

	// packet phases
	localparam logic [1:0] PH_SCAN  = 2'd0;
	localparam logic [1:0] PH_SKIP1 = 2'd1;
	localparam logic [1:0] PH_SKIP2 = 2'd2;

	// work left for the repeat stage
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_LOOK  = 2'd1;
	localparam logic [1:0] KIND_BREAK = 2'd2;
	localparam logic [1:0] KIND_TICK  = 2'd3;

	// register indexes
	localparam logic REG_REPEAT_DELAY = 1'b0;

	typedef struct packed {
		logic [1:0] kind;
		logic       toggle;
	} dec_t;

endpackage

// ===== sv/kbd_ifs.sv =====
// Stream channel interfaces for input items and result items.
interface kbd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] data_byte;
	logic [7:0] map_index;
	logic [7:0] map_value;

	modport source (output valid, mode, data_byte, map_index, map_value, input ready);
	modport sink (input valid, mode, data_byte, map_index, map_value, output ready);
endinterface

interface kbd_out_if;
	logic       valid;
	logic       ready;
	logic       char_valid;
	logic [7:0] char_code;
	logic       cursor_toggle;

	modport source (output valid, char_valid, char_code, cursor_toggle, input ready);
	modport sink (input valid, char_valid, char_code, cursor_toggle, output ready);
endinterface

// ===== sv/kbd_apb.sv =====
// APB register file holding the autorepeat delay.
module kbd_apb (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  repeat_delay
);

	logic [7:0] delay_q;
	logic       reg_idx;

	assign reg_idx = paddr[2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= kbd_pkg::REPEAT_DELAY_RESET;
		end else if (psel && penable && pwrite && pready
				&& reg_idx == kbd_pkg::REG_REPEAT_DELAY) begin
			delay_q <= pwdata[7:0];
		end
	end

	assign prdata       = (reg_idx == kbd_pkg::REG_REPEAT_DELAY) ? {24'd0, delay_q} : 32'd0;
	assign repeat_delay = delay_q;

endmodule

// ===== sv/kbd_keymap.sv =====
// Two-plane keymap: synchronous memory with per-entry valid bits cleared at reset.
module kbd_keymap (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [kbd_pkg::MAP_AW-1:0] wr_addr,
	input  logic [7:0]                wr_data,
	input  logic                      rd_en,
	input  logic [kbd_pkg::MAP_AW-1:0] rd_addr,
	output logic [7:0]                rd_data
);

	logic [7:0]                    mem [kbd_pkg::MAP_DEPTH];
	logic [kbd_pkg::MAP_DEPTH-1:0] vld_q;
	logic [7:0]                    data_q;
	logic                          hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr];
		end
	end

	// unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = hit_q ? data_q : 8'd0;

endmodule

// ===== sv/kbd_front.sv =====
// Accept stage: packet phase, shift count, blink counter and keymap access.
module kbd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [1:0]                 mode,
	input  logic [7:0]                 data_byte,
	input  logic [7:0]                 map_index,
	input  logic [7:0]                 map_value,
	output logic                       map_wr_en,
	output logic [kbd_pkg::MAP_AW-1:0] map_wr_addr,
	output logic [7:0]                 map_wr_data,
	output logic                       map_rd_en,
	output logic [kbd_pkg::MAP_AW-1:0] map_rd_addr,
	output kbd_pkg::dec_t              dec
);

	logic [1:0]                   phase_q, phase_d;
	logic [7:0]                   shift_q, shift_d;
	logic [kbd_pkg::BLINK_BITS-1:0] blink_q, blink_d;

	always_comb begin
		phase_d    = phase_q;
		shift_d    = shift_q;
		blink_d    = blink_q;
		dec.kind   = kbd_pkg::KIND_NONE;
		dec.toggle = 1'b0;
		case (mode)
			kbd_pkg::MODE_BYTE: begin
				case (phase_q)
					kbd_pkg::PH_SCAN: begin
						if ((data_byte & kbd_pkg::MOUSE_MASK) == kbd_pkg::MOUSE_HEADER) begin
							phase_d = kbd_pkg::PH_SKIP1;
						end else if (data_byte == kbd_pkg::LSHIFT_MAKE
								|| data_byte == kbd_pkg::RSHIFT_MAKE) begin
							shift_d = shift_q + 8'd1;
						end else if (data_byte == kbd_pkg::LSHIFT_BREAK
								|| data_byte == kbd_pkg::RSHIFT_BREAK) begin
							shift_d = shift_q - 8'd1;
						end else if (!data_byte[7]) begin
							dec.kind = kbd_pkg::KIND_LOOK;
						end else begin
							dec.kind = kbd_pkg::KIND_BREAK;
						end
					end
					kbd_pkg::PH_SKIP1: phase_d = kbd_pkg::PH_SKIP2;
					default:           phase_d = kbd_pkg::PH_SCAN;
				endcase
			end
			kbd_pkg::MODE_TICK: begin
				blink_d    = blink_q + 1'b1;
				dec.kind   = kbd_pkg::KIND_TICK;
				dec.toggle = (blink_d == '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= kbd_pkg::PH_SCAN;
			shift_q <= 8'd0;
			blink_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			shift_q <= shift_d;
			blink_q <= blink_d;
		end
	end

	// lookup uses the shift count as it stands; a lookup byte never changes it
	assign map_rd_en   = accept && dec.kind == kbd_pkg::KIND_LOOK;
	assign map_rd_addr = {shift_q != 8'd0, data_byte[6:0]};
	assign map_wr_en   = accept && mode == kbd_pkg::MODE_LOAD;
	assign map_wr_addr = map_index;
	assign map_wr_data = map_value;

endmodule

// ===== sv/kbd_repeat.sv =====
// Repeat stage: held character, repeat count and the output register.
module kbd_repeat (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  kbd_pkg::dec_t dec,
	input  logic [7:0]    map_data,
	input  logic [7:0]    repeat_delay,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          char_valid,
	output logic [7:0]    char_code,
	output logic          cursor_toggle
);

	kbd_pkg::dec_t              dec_s1;
	logic                       vld_s1;
	logic                       go;
	logic [7:0]                 rc_q, rc_d;
	logic [kbd_pkg::TICKS_W-1:0] ticks_q, ticks_d;
	logic                       emit;
	logic [7:0]                 code;
	logic                       out_vld_q, cv_q, ct_q;
	logic [7:0]                 cc_q;

	assign go       = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || go;

	always_comb begin
		rc_d    = rc_q;
		ticks_d = ticks_q;
		emit    = 1'b0;
		code    = 8'd0;
		case (dec_s1.kind)
			kbd_pkg::KIND_LOOK: begin
				rc_d = map_data;
				if (map_data != 8'd0) begin
					ticks_d = '0;
					emit    = 1'b1;
					code    = map_data;
				end
			end
			kbd_pkg::KIND_BREAK: rc_d = 8'd0;
			kbd_pkg::KIND_TICK: begin
				if (rc_q != 8'd0) begin
					if (ticks_q != kbd_pkg::TICKS_MAX) begin
						ticks_d = ticks_q + 1'b1;
					end
					if (ticks_d > {{(kbd_pkg::TICKS_W-8){1'b0}}, repeat_delay}) begin
						emit = 1'b1;
						code = rc_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			rc_q      <= 8'd0;
			ticks_q   <= '0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (go) begin
				vld_s1 <= 1'b0;
			end
			if (go) begin
				out_vld_q <= 1'b1;
				rc_q      <= rc_d;
				ticks_q   <= ticks_d;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1 <= dec;
		end
		if (go) begin
			cv_q <= emit;
			cc_q <= code;
			ct_q <= dec_s1.toggle;
		end
	end

	assign out_valid     = out_vld_q;
	assign char_valid    = cv_q;
	assign char_code     = cc_q;
	assign cursor_toggle = ct_q;

endmodule

// ===== sv/keyboard_scan_decoder_autorepeat.sv =====
// Top level of the keyboard scan decoder with autorepeat and cursor blink.
//
// Input channel in_ch carries one item per beat: a received keyboard byte,
// a frame tick, or a keymap load (mode 0, 1, 2; mode 3 does nothing).
// Output channel out_ch returns exactly one result beat per input beat,
// in order: char_valid/char_code for a delivered character and
// cursor_toggle on every 2^BLINK_BITS-th tick.
// The APB port holds repeat_delay at address 0 (reset value 10); write it
// only while no beat is in flight.
// Path from input acceptance to the result on out_ch: the accept cycle issues
// the synchronous keymap read; the repeat stage then resolves the held
// character and repeat count into the output register.
// Throughput is one beat per cycle while out_ch does not stall; the keymap
// read port and the repeat stage each take one item per cycle.
// Reset clears the packet phase, shift count, repeat and blink counters,
// and the keymap's per-entry valid bits, so the whole map reads zero at once.
// When out_ch stalls, one result waits in the output register and one item
// in the repeat stage; in_ch.ready then drops until the output drains.
module keyboard_scan_decoder_autorepeat (
	input  logic        clk,
	input  logic        arst_n,
	kbd_in_if.sink      in_ch,
	kbd_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                       accept;
	logic [7:0]                 repeat_delay;
	logic                       map_wr_en, map_rd_en;
	logic [kbd_pkg::MAP_AW-1:0] map_wr_addr, map_rd_addr;
	logic [7:0]                 map_wr_data, map_rd_data;
	kbd_pkg::dec_t              dec;

	// beat taken on in_ch
	assign accept = in_ch.valid && in_ch.ready;

	kbd_apb u_apb (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.repeat_delay (repeat_delay)
	);

	// decode the item, advance the scalar counters, drive the keymap port
	kbd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.mode        (in_ch.mode),
		.data_byte   (in_ch.data_byte),
		.map_index   (in_ch.map_index),
		.map_value   (in_ch.map_value),
		.map_wr_en   (map_wr_en),
		.map_wr_addr (map_wr_addr),
		.map_wr_data (map_wr_data),
		.map_rd_en   (map_rd_en),
		.map_rd_addr (map_rd_addr),
		.dec         (dec)
	);

	// a load followed at once by a lookup of the same entry sees the new
	// value: the write lands before the read takes its data
	kbd_keymap u_keymap (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (map_wr_en),
		.wr_addr (map_wr_addr),
		.wr_data (map_wr_data),
		.rd_en   (map_rd_en),
		.rd_addr (map_rd_addr),
		.rd_data (map_rd_data)
	);

	// resolve the held character and hold results until taken
	kbd_repeat u_repeat (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.dec           (dec),
		.map_data      (map_rd_data),
		.repeat_delay  (repeat_delay),
		.in_ready      (in_ch.ready),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.char_valid    (out_ch.char_valid),
		.char_code     (out_ch.char_code),
		.cursor_toggle (out_ch.cursor_toggle)
	);

`ifndef NO_ASSERTIONS
	// a delivered character is never zero, and no character means code zero
	a_code_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.char_valid == (out_ch.char_code != 8'd0)))
		else $error("char_code disagrees with char_valid");

	// a beat taken while the output is stalled fills the repeat stage
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && out_ch.valid && !out_ch.ready) |=> (out_ch.ready || !in_ch.ready))
		else $error("input accepted with both stages full");
`endif

endmodule
